// ===== design/sacache_pkg.sv =====
// Shared types and constants for the set-associative cache hit/miss unit.
// Used by sacache_ctrl, sacache_dp and set_assoc_cache_hit_miss_unit.
package sacache_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned IDX_VAL_W = 15;  // widest masked set index (index_bits up to 15)
  localparam int unsigned NWAY_W    = 5;   // holds an active way count up to 16
  localparam int unsigned OUT_WAY_W = 3;
  localparam int unsigned LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_RESET = 16'hACE1;

  localparam logic [1:0] POL_RANDOM = 2'd0;
  localparam logic [1:0] POL_LFU    = 2'd1;
  localparam logic [1:0] POL_LRU    = 2'd2;
  localparam logic [1:0] POL_FIXED  = 2'd3;

  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_OFFSET = 2'd1;
  localparam logic [1:0] CFG_INDEX  = 2'd2;
  localparam logic [1:0] CFG_WAYS   = 2'd3;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_MOD   = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_SCAN  = 7'b0010000,
    ST_WRITE = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic clr;       // write a zero row at the clear pointer
    logic load;      // capture the address of an accepted transfer
    logic mod_step;  // one step of the set-index remainder
    logic rd;        // read the set row
    logic scan_step; // examine one way
    logic wr;        // write back the updated row
    logic out_load;  // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic scan_done;
  } sts_t;

endpackage

// ===== design/sacache_ctrl.sv =====
// Controller state machine for the cache hit/miss unit.
// Depends on sacache_pkg; drives sacache_dp through cmd_t, reads sts_t.
module sacache_ctrl
  import sacache_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/sacache_dp.sv =====
// Datapath of the cache hit/miss unit: config registers, set store,
// index remainder unit, way scan, row update and LFSR. Uses sacache_pkg.
module sacache_dp
  import sacache_pkg::*;
#(
  parameter int unsigned SETS         = 1024,
  parameter int unsigned WAYS         = 8,
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [3:0]           cfg_data_i,
  input  logic [ADDR_W-1:0]    address_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic [NWAY_W-1:0]    nways_o,
  output logic                 hit_o,
  output logic [OUT_WAY_W-1:0] way_o
);

  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CB    = COUNTER_BITS;
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
  localparam int unsigned SET_L = (SETS > 1) ? $clog2(SETS) : 0;
  localparam int unsigned Q_SH  = IDX_VAL_W + SET_L;
  localparam logic [31:0] RECIP  = 32'(((64'd1 << Q_SH) / SETS) + 1);
  localparam logic [31:0] SETS_W = 32'(SETS);

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] tag;
    logic [CB-1:0]     use_c;
    logic [CB-1:0]     age;
  } entry_t;
  typedef entry_t [WAYS-1:0] row_t;

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

  logic [1:0] policy_q;
  logic [3:0] offset_q, index_q;
  logic [1:0] wayb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_LRU;
      offset_q <= 4'd4;
      index_q  <= 4'd10;
      wayb_q   <= 2'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POLICY: policy_q <= cfg_data_i[1:0];
        CFG_OFFSET: offset_q <= cfg_data_i;
        CFG_INDEX:  index_q  <= cfg_data_i;
        CFG_WAYS:   wayb_q   <= cfg_data_i[1:0];
        default:    ;
      endcase
    end
  end

  logic [NWAY_W-1:0] nways_pow, nways;
  assign nways_pow = NWAY_W'(1) << wayb_q;
  assign nways     = (nways_pow > NWAY_W'(WAYS)) ? NWAY_W'(WAYS) : nways_pow;
  assign nways_o   = nways;

  // address split; remainder by SETS via reciprocal multiply, two steps
  logic [ADDR_W-1:0]    shifted;
  logic [IDX_VAL_W:0]   mask;
  logic [ADDR_W-1:0]    tag_q;
  logic [IDX_VAL_W-1:0] mod_v_q, quo_q;
  logic                 mod_cnt_q;
  logic [SET_W-1:0]     set_q;
  logic [31:0]          quo_prod, rem_full;

  assign shifted  = address_i >> offset_q;
  assign mask     = ((IDX_VAL_W+1)'(1) << index_q) - 1'b1;
  assign quo_prod = 32'(mod_v_q) * RECIP;
  assign rem_full = 32'(mod_v_q) - 32'(quo_q) * SETS_W;
  assign sts_o.mod_done = mod_cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tag_q     <= address_i >> (6'(offset_q) + 6'(index_q));
      mod_v_q   <= shifted[IDX_VAL_W-1:0] & mask[IDX_VAL_W-1:0];
      mod_cnt_q <= 1'b0;
    end else if (cmd_i.mod_step) begin
      mod_cnt_q <= 1'b1;
      if (!mod_cnt_q) quo_q <= IDX_VAL_W'(quo_prod >> Q_SH);
      else set_q <= rem_full[SET_W-1:0];
    end
  end

  // clearing pass
  logic [SET_W-1:0] clr_q;
  assign sts_o.clr_done = (clr_q == SET_W'(SETS-1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr && !sts_o.clr_done) clr_q <= clr_q + 1'b1;
  end

  // set store
  row_t             mem [SETS];
  row_t             row_q, row_new;
  logic             mem_we;
  logic [SET_W-1:0] mem_addr;
  row_t             mem_wdata;

  assign mem_we    = cmd_i.clr || cmd_i.wr;
  assign mem_addr  = cmd_i.clr ? clr_q : set_q;
  assign mem_wdata = cmd_i.clr ? row_t'('0) : row_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (cmd_i.rd) row_q <= mem[set_q];
  end

  // way scan
  logic [WAY_W-1:0] w_q, hit_w_q, lfu_w_q, lru_w_q;
  logic             hit_f_q;
  logic [CB-1:0]    least_q, most_q;
  entry_t           cur;
  logic             act;

  assign cur = row_q[w_q];
  assign act = (NWAY_W'(w_q) < nways);
  assign sts_o.scan_done = (w_q == WAY_W'(WAYS-1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      w_q     <= '0;
      hit_f_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      w_q <= w_q + 1'b1;
      if (act) begin
        if (cur.valid && cur.tag == tag_q && !hit_f_q) begin
          hit_f_q <= 1'b1;
          hit_w_q <= w_q;
        end
        if (w_q == '0 || cur.use_c < least_q) begin
          least_q <= cur.use_c;
          lfu_w_q <= w_q;
        end
        if (w_q == '0 || cur.age > most_q) begin
          most_q  <= cur.age;
          lru_w_q <= w_q;
        end
      end
    end
  end

  // row update
  logic [LFSR_W-1:0] lfsr_q, lfsr_nxt;
  logic [WAY_W-1:0]  victim, way_mask;
  logic [NWAY_W-1:0] nways_m1, victim_ext;

  assign lfsr_nxt   = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LFSR_W-1:1]};
  assign nways_m1   = nways - 1'b1;
  assign way_mask   = nways_m1[WAY_W-1:0];
  assign victim_ext = NWAY_W'(victim);

  always_comb begin
    if (hit_f_q) victim = hit_w_q;
    else begin
      unique case (policy_q)
        POL_RANDOM: victim = lfsr_nxt[WAY_W-1:0] & way_mask;
        POL_LFU:    victim = lfu_w_q;
        POL_LRU:    victim = lru_w_q;
        default:    victim = '0;
      endcase
    end
  end

  always_comb begin
    logic aging;
    aging   = hit_f_q || (policy_q == POL_LRU);
    row_new = row_q;
    for (int w = 0; w < WAYS; w++) begin
      if (NWAY_W'(w) < nways) begin
        if (WAY_W'(w) == victim) begin
          if (aging) row_new[w].age = '0;
          if (hit_f_q) row_new[w].use_c = sat_inc(row_q[w].use_c);
          else begin
            row_new[w].tag   = tag_q;
            row_new[w].valid = 1'b1;
            if (policy_q == POL_LFU) row_new[w].use_c = CB'(1);
          end
        end else if (aging) begin
          row_new[w].age = sat_inc(row_q[w].age);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lfsr_q <= LFSR_RESET;
    else if (cmd_i.wr && !hit_f_q && policy_q == POL_RANDOM) lfsr_q <= lfsr_nxt;
  end

  // result and output register
  logic                 res_hit_q;
  logic [OUT_WAY_W-1:0] res_way_q, way_oq;
  logic                 hit_oq;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      res_hit_q <= hit_f_q;
      res_way_q <= victim_ext[OUT_WAY_W-1:0];
    end
    if (cmd_i.out_load) begin
      hit_oq <= res_hit_q;
      way_oq <= res_way_q;
    end
  end

  assign hit_o = hit_oq;
  assign way_o = way_oq;

endmodule

// ===== design/set_assoc_cache_hit_miss_unit.sv =====
// Set-associative cache hit/miss unit: one address in, hit flag and way out.
// Each transfer passes, from acceptance, through the set-index remainder
// (reciprocal multiply, then subtract), the row read, a scan of every way,
// the write back and the load of the output register, then returns to idle;
// no new address is accepted before then, and a held output register stalls
// the load. After reset a clearing pass writes every set row, during which no
// address is accepted. Uses sacache_pkg, sacache_ctrl and sacache_dp.
module set_assoc_cache_hit_miss_unit
  import sacache_pkg::*;
#(
  parameter int unsigned SETS         = 1024,
  parameter int unsigned WAYS         = 8,
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [3:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ADDR_W-1:0]    address_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o,
  output logic [OUT_WAY_W-1:0] way_o
);

  cmd_t              cmd;
  sts_t              sts;
  logic [NWAY_W-1:0] nways;

  sacache_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sacache_dp #(
    .SETS         (SETS),
    .WAYS         (WAYS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .address_i   (address_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .nways_o     (nways),
    .hit_o       (hit_o),
    .way_o       (way_o)
  );

`ifndef ASSERT_OFF
  a_no_clr_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.clr && cmd.wr))
    else $error("clear and write back together");

  a_out_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten");

  a_way_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (NWAY_W'(way_o) < nways))
    else $error("reported way outside active ways");
`endif

endmodule
